### rtl/smooth_normal_accumulator_unit_defines.svh
// Assertion macros shared by the smooth normal accumulator RTL
`ifndef SMOOTH_NORMAL_ACCUMULATOR_UNIT_DEFINES_SVH
`define SMOOTH_NORMAL_ACCUMULATOR_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define SNA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define SNA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/snacc_pkg.sv
// Types and constants of the smooth normal accumulator
`default_nettype none
package snacc_pkg;

  localparam int KEY_W = 32;
  localparam int SUM_W = 32;
  localparam int NRM_W = 16;
  localparam int SQ_W  = 64;
  localparam int LEN_W = 32;
  localparam int QUO_W = 15;

  localparam logic [1:0] OP_CLEAR = 2'd0;

  localparam logic [2:0] ST_ACCUM    = 3'd0;
  localparam logic [2:0] ST_DROP     = 3'd1;
  localparam logic [2:0] ST_SMOOTH   = 3'd2;
  localparam logic [2:0] ST_FALLBACK = 3'd3;
  localparam logic [2:0] ST_CLEAR    = 3'd4;

  typedef enum logic {
    IT_SQRT = 1'b0,
    IT_DIV  = 1'b1
  } iter_mode_t;

  typedef struct packed {
    logic       start;
    iter_mode_t mode;
  } iter_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_sts_t;

endpackage
`default_nettype wire

### rtl/snacc_table.sv
// Key and sum storage, one write port and one registered read port
`default_nettype none
module snacc_table #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [AW-1:0]                  wr_addr,
  input  logic [3*snacc_pkg::KEY_W-1:0]  wr_key,
  input  logic [3*snacc_pkg::SUM_W-1:0]  wr_sum,
  input  logic [AW-1:0]                  rd_addr,
  output logic [3*snacc_pkg::KEY_W-1:0]  rd_key,
  output logic [3*snacc_pkg::SUM_W-1:0]  rd_sum
);
  import snacc_pkg::*;

  logic [3*KEY_W-1:0] key_mem [DEPTH];
  logic [3*SUM_W-1:0] sum_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      sum_mem[wr_addr] <= wr_sum;
    end
    rd_key <= key_mem[rd_addr];
    rd_sum <= sum_mem[rd_addr];
  end

endmodule
`default_nettype wire

### rtl/snacc_iter.sv
// Shared iterative unit: bitwise integer square root and restoring divide
`default_nettype none
module snacc_iter (
  input  logic                         clk,
  input  logic                         rst,
  input  snacc_pkg::iter_ctl_t         ctl,
  input  logic [snacc_pkg::SQ_W-1:0]   radicand,
  input  logic [snacc_pkg::SUM_W-1:0]  div_mag,
  input  logic [snacc_pkg::LEN_W-1:0]  div_len,
  output snacc_pkg::iter_sts_t         sts,
  output logic [snacc_pkg::LEN_W-1:0]  root,
  output logic [snacc_pkg::QUO_W-1:0]  quo
);
  import snacc_pkg::*;

  iter_mode_t         mode_r;
  logic [5:0]         cnt;
  logic [SQ_W-1:0]    rem;
  logic [SQ_W-1:0]    res;
  logic [SQ_W-1:0]    bitv;
  logic [SQ_W-1:0]    trial;
  logic [LEN_W-1:0]   drem;
  logic [QUO_W-1:0]   dlow;
  logic [LEN_W:0]     r2;
  logic [LEN_W:0]     r2_diff;

  assign trial   = res + bitv;
  assign r2      = {drem, dlow[QUO_W-1]};
  assign r2_diff = r2 - {1'b0, div_len};
  assign root    = res[LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sts.busy <= 1'b0;
      sts.done <= 1'b0;
      cnt      <= '0;
      mode_r   <= IT_SQRT;
    end else begin
      sts.done <= 1'b0;
      if (ctl.start) begin
        sts.busy <= 1'b1;
        mode_r   <= ctl.mode;
        cnt      <= (ctl.mode == IT_SQRT) ? 6'd32 : 6'(QUO_W);
      end else if (sts.busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          sts.busy <= 1'b0;
          sts.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      if (ctl.mode == IT_SQRT) begin
        rem  <= radicand;
        res  <= '0;
        bitv <= {2'b01, {(SQ_W-2){1'b0}}};
      end else begin
        // quotient fits 15 bits since mag <= len: preload the high part
        drem <= {1'b0, div_mag[SUM_W-1:1]};
        dlow <= {div_mag[0], {(QUO_W-1){1'b0}}};
        quo  <= '0;
      end
    end else if (sts.busy) begin
      if (mode_r == IT_SQRT) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
      end else begin
        if (r2 >= {1'b0, div_len}) begin
          drem <= r2_diff[LEN_W-1:0];
          quo  <= {quo[QUO_W-2:0], 1'b1};
        end else begin
          drem <= r2[LEN_W-1:0];
          quo  <= {quo[QUO_W-2:0], 1'b0};
        end
        dlow <= dlow << 1;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/smooth_normal_accumulator_unit.sv
// Top level of the smooth normal accumulator: sequencer, key quantizer, welding table
//
//  channel  signals                                   dir
//  input    in_valid/in_ready, opcode, pos_*, normal_* in
//  output   out_valid/out_ready, status, smooth_*       out
//  config   cfg_valid/cfg_ready, cfg_data (key_scale)   in
//
// Accumulate probes the table entries by a linear search through the single read port.
// Query then forms the squared length, the root and the three divides on the shared
// iterative unit, after the search.
// One item at a time; in_ready is low until the result is loaded into the output register.
// A waiting result does not block accepting the next item. No clearing pass after reset.
`default_nettype none
module smooth_normal_accumulator_unit #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [15:0]                         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          opcode,
  input  logic signed [31:0]                  pos_x,
  input  logic signed [31:0]                  pos_y,
  input  logic signed [31:0]                  pos_z,
  input  logic signed [snacc_pkg::NRM_W-1:0]  normal_x,
  input  logic signed [snacc_pkg::NRM_W-1:0]  normal_y,
  input  logic signed [snacc_pkg::NRM_W-1:0]  normal_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [2:0]                          status,
  output logic signed [snacc_pkg::NRM_W-1:0]  smooth_x,
  output logic signed [snacc_pkg::NRM_W-1:0]  smooth_y,
  output logic signed [snacc_pkg::NRM_W-1:0]  smooth_z
);
  import snacc_pkg::*;
`include "smooth_normal_accumulator_unit_defines.svh"

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_QUANT = 9'b000000010,
    S_RD    = 9'b000000100,
    S_CMP   = 9'b000001000,
    S_DEC   = 9'b000010000,
    S_SQ    = 9'b000100000,
    S_SQRT  = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state;
  logic [15:0]             key_scale;
  logic [CW-1:0]           count;
  logic [CW-1:0]           idx;
  logic                    found;
  logic [1:0]              op_r;
  logic [1:0]              ax;
  logic [1:0]              k;
  logic pend;
  logic signed [31:0]      pos_r [3];
  logic signed [NRM_W-1:0] nrm_r [3];
  logic [KEY_W-1:0]        key_r [3];
  logic signed [SUM_W-1:0] sum_r [3];
  logic signed [NRM_W-1:0] res_s [3];
  logic [2:0]              res_status;
  logic [SQ_W-1:0]         prod_sq;
  logic [SQ_W-1:0]         acc;
  logic [SQ_W-1:0]         sq_total;

  logic signed [31:0]      pos_sel;
  logic signed [48:0]      qprod;
  logic signed [48:0]      qadj;
  logic signed [48:0]      qshift;
  logic [SUM_W-1:0]        mag_sel;
  logic signed [SUM_W-1:0] sum_sel;
  logic                    tbl_wr;
  logic [AW-1:0]           tbl_waddr;
  logic [3*KEY_W-1:0]      tbl_wkey;
  logic [3*SUM_W-1:0]      tbl_wsum;
  logic [3*KEY_W-1:0]      rd_key;
  logic [3*SUM_W-1:0]      rd_sum;
  logic                    is_accum;
  logic                    room;
  iter_ctl_t               it_ctl;
  iter_sts_t               it_sts;
  logic [LEN_W-1:0]        root;
  logic [QUO_W-1:0]        quo;
  logic signed [NRM_W-1:0] qs;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign is_accum  = !op_r[1];
  assign room      = (count < CW'(TABLE_ENTRIES));

  // key = trunc(pos * key_scale / 65536), rounding toward zero
  always_comb begin
    case (ax)
      2'd0:    pos_sel = pos_r[0];
      2'd1:    pos_sel = pos_r[1];
      default: pos_sel = pos_r[2];
    endcase
    qprod  = pos_sel * $signed({1'b0, key_scale});
    qadj   = qprod + (qprod[48] ? 49'sd65535 : 49'sd0);
    qshift = qadj >>> 16;
  end

  always_comb begin
    case (k)
      2'd0:    sum_sel = sum_r[0];
      2'd1:    sum_sel = sum_r[1];
      2'd2:    sum_sel = sum_r[2];
      default: sum_sel = '0;
    endcase
    mag_sel  = sum_sel[SUM_W-1] ? (~sum_sel + 32'd1) : sum_sel;
    sq_total = acc + prod_sq;
    qs       = sum_sel[SUM_W-1] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  end

  function automatic logic [SUM_W-1:0] sat_add(logic signed [SUM_W-1:0] a,
                                               logic signed [NRM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {{(SUM_W-NRM_W+1){b[NRM_W-1]}}, b};
    if (s[SUM_W] != s[SUM_W-1])
      sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    else
      sat_add = s[SUM_W-1:0];
  endfunction

  always_comb begin
    tbl_wr    = (state == S_DEC) && is_accum && (found || room);
    tbl_waddr = found ? idx[AW-1:0] : count[AW-1:0];
    tbl_wkey  = {key_r[2], key_r[1], key_r[0]};
    if (found)
      tbl_wsum = {sat_add(sum_r[2], nrm_r[2]), sat_add(sum_r[1], nrm_r[1]),
                  sat_add(sum_r[0], nrm_r[0])};
    else
      tbl_wsum = {{(SUM_W-NRM_W){nrm_r[2][NRM_W-1]}}, nrm_r[2],
                  {(SUM_W-NRM_W){nrm_r[1][NRM_W-1]}}, nrm_r[1],
                  {(SUM_W-NRM_W){nrm_r[0][NRM_W-1]}}, nrm_r[0]};
  end

  snacc_table #(.DEPTH(TABLE_ENTRIES), .AW(AW)) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr),
    .wr_addr (tbl_waddr),
    .wr_key  (tbl_wkey),
    .wr_sum  (tbl_wsum),
    .rd_addr (idx[AW-1:0]),
    .rd_key  (rd_key),
    .rd_sum  (rd_sum)
  );

  always_comb begin
    it_ctl.start = 1'b0;
    it_ctl.mode  = IT_SQRT;
    if (state == S_SQ && k == 2'd3 && sq_total != '0) begin
      it_ctl.start = 1'b1;
    end else if (state == S_DIV && pend) begin
      it_ctl.start = 1'b1;
      it_ctl.mode  = IT_DIV;
    end
  end

  snacc_iter u_iter (
    .clk      (clk),
    .rst      (rst),
    .ctl      (it_ctl),
    .radicand (sq_total),
    .div_mag  (mag_sel),
    .div_len  (root),
    .sts      (it_sts),
    .root     (root),
    .quo      (quo)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      key_scale <= 16'd10000;
      count     <= '0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready)
        key_scale <= cfg_data;
      if (state == S_OUT && (!out_valid || out_ready))
        out_valid <= 1'b1;
      else if (out_valid && out_ready)
        out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (opcode == OP_CLEAR) begin
              count <= '0;
              state <= S_OUT;
            end else begin
              state <= S_QUANT;
            end
          end
        end
        S_QUANT: begin
          if (ax == 2'd2)
            state <= (count == '0) ? S_DEC : S_RD;
        end
        S_RD: state <= S_CMP;
        S_CMP: begin
          if (rd_key == {key_r[2], key_r[1], key_r[0]} || idx + CW'(1) == count)
            state <= S_DEC;
          else
            state <= S_RD;
        end
        S_DEC: begin
          if (is_accum && !found && room)
            count <= count + CW'(1);
          state <= (!is_accum && found) ? S_SQ : S_OUT;
        end
        S_SQ: begin
          if (k == 2'd3)
            state <= (sq_total != '0) ? S_SQRT : S_OUT;
        end
        S_SQRT: begin
          if (it_sts.done) begin
            state <= S_DIV;
            pend  <= 1'b1;
          end
        end
        S_DIV: begin
          pend <= it_sts.done && (k != 2'd2);
          if (it_sts.done && k == 2'd2)
            state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready)
            state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op_r       <= opcode;
        pos_r[0]   <= pos_x;
        pos_r[1]   <= pos_y;
        pos_r[2]   <= pos_z;
        nrm_r[0]   <= normal_x;
        nrm_r[1]   <= normal_y;
        nrm_r[2]   <= normal_z;
        ax         <= 2'd0;
        found      <= 1'b0;
        idx        <= '0;
        res_status <= ST_CLEAR;
        res_s[0]   <= '0;
        res_s[1]   <= '0;
        res_s[2]   <= '0;
      end
      S_QUANT: begin
        key_r[ax] <= qshift[KEY_W-1:0];
        ax        <= ax + 2'd1;
      end
      S_CMP: begin
        if (rd_key == {key_r[2], key_r[1], key_r[0]}) begin
          found    <= 1'b1;
          sum_r[0] <= rd_sum[0*SUM_W +: SUM_W];
          sum_r[1] <= rd_sum[1*SUM_W +: SUM_W];
          sum_r[2] <= rd_sum[2*SUM_W +: SUM_W];
        end else if (idx + CW'(1) != count) begin
          idx <= idx + CW'(1);
        end
      end
      S_DEC: begin
        k   <= 2'd0;
        acc <= '0;
        if (is_accum) begin
          res_status <= (found || room) ? ST_ACCUM : ST_DROP;
        end else begin
          res_status <= ST_FALLBACK;
          res_s[0]   <= nrm_r[0];
          res_s[1]   <= nrm_r[1];
          res_s[2]   <= nrm_r[2];
        end
      end
      S_SQ: begin
        // squares one per cycle, each added to acc in the cycle after
        if (k != 2'd3) begin
          prod_sq <= mag_sel * mag_sel;
          k       <= k + 2'd1;
        end else begin
          k <= 2'd0;
        end
        if (k != 2'd0)
          acc <= sq_total;
      end
      S_DIV: begin
        if (it_sts.done) begin
          res_s[k]   <= qs;
          k          <= k + 2'd1;
          res_status <= ST_SMOOTH;
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          status   <= res_status;
          smooth_x <= res_s[0];
          smooth_y <= res_s[1];
          smooth_z <= res_s[2];
        end
      end
      default: ;
    endcase
  end

  `SNA_ASSERT_IMP(a_count_bound, 1'b1, count <= CW'(TABLE_ENTRIES), "entry count exceeds table")
  `SNA_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
  `SNA_ASSERT_IMP(a_iter_done_state, it_sts.done, state == S_SQRT || state == S_DIV, "stray iter done")
  `SNA_ASSERT_IMP(a_smooth_range, out_valid && status == ST_SMOOTH, smooth_x <= 16'sd16384 && smooth_x >= -16'sd16384, "smooth x out of range")

endmodule
`default_nettype wire
